FILE: design/ute_pkg.sv
`default_nettype none
package ute_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int DATA_WIDTH  = 8;
  localparam int TAIL_DEPTH  = 8;
  localparam int TAIL_AW     = $clog2(TAIL_DEPTH);
  localparam int FILL_W      = $clog2(TAIL_DEPTH + 1);
  localparam int CFG_W       = LIMIT_WIDTH;
  localparam int CFG_IDX_W   = 1;
  localparam int EXT_W       = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 2;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET      = '1;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MIN        = LIMIT_WIDTH'(1);
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MIN_MARKED = LIMIT_WIDTH'(3);
  localparam logic [DATA_WIDTH-1:0]  DOT_CHAR         = 8'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAR_LIMIT = 1'b0,
    REG_MARK       = 1'b1
  } cfg_reg_t;

  // Continuation bytes still expected, with the special first-continuation ranges
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TAIL1 = 3'd1,
    PH_TAIL2 = 3'd2,
    PH_TAIL3 = 3'd3,
    PH_E0    = 3'd4,
    PH_ED    = 3'd5,
    PH_F0    = 3'd6,
    PH_F4    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_DOTS  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [DATA_WIDTH-1:0]   data;
    logic [FILL_W-1:0]       fill;
    logic                    truncated;
    logic                    non_ascii;
    logic [COUNT_WIDTH-1:0]  count;
    logic                    saturated;
  } emit_cmd_t;

endpackage
`default_nettype wire

FILE: design/utf8_truncate_with_ellipsis.sv
// Each input item is registered, and its result is then registered in the result register.
// Throughput: one item per cycle while each item yields at most one result and out_ready
//   holds; the output sequencer stays busy over a ".." pair and a tail flush of up to 8 bytes,
//   and a byte headed for the tail buffer waits until the sequencer can take a command.
// Reset (synchronous, rst_n low): per-string state cleared, char_limit = 65535,
//   mark_truncation = 0; the 8-byte tail buffer is not cleared.
`default_nettype none
module utf8_truncate_with_ellipsis (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ute_pkg::DATA_WIDTH-1:0]   in_byte_value,
  input  wire logic                             in_is_end,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ute_pkg::DATA_WIDTH-1:0]        out_byte,
  output logic                                  out_has_byte,
  output logic                                  out_is_last,
  output logic                                  out_truncated,
  output logic                                  out_non_ascii,
  output logic [ute_pkg::COUNT_WIDTH-1:0]       out_char_total,
  output logic                                  out_count_saturated,
  input  wire logic                             cfg_wr_en,
  input  wire logic [ute_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ute_pkg::CFG_W-1:0]        cfg_data
);
  import ute_pkg::*;

  logic                   in_valid_r;
  logic [DATA_WIDTH-1:0]  in_byte_r;
  logic                   in_end_r;

  logic [LIMIT_WIDTH-1:0] limit_r;
  logic                   mark_r;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] chars_r, chars_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   cut_r, cut_nxt;
  logic                   high_r, high_nxt;
  logic                   stuck_r, stuck_nxt;
  logic [DATA_WIDTH-1:0]  tail_mem [TAIL_DEPTH];

  phase_t                 dec_phase;
  logic                   dec_cont;
  logic [LIMIT_WIDTH-1:0] lim;
  logic [EXT_W-1:0]       lim_ext;
  logic [EXT_W-1:0]       chars_ext;
  logic [EXT_W-1:0]       index;
  logic                   route;
  logic                   tail_we;
  emit_cmd_t              cmd;
  logic                   cmd_ready;
  logic                   take;
  logic [TAIL_AW-1:0]     rd_idx;

  ute_decode u_decode (
    .byte_value (in_byte_r),
    .phase      (phase_r),
    .next_phase (dec_phase),
    .is_cont    (dec_cont)
  );

  assign chars_ext = EXT_W'(chars_r);
  assign lim_ext   = EXT_W'(lim);

  always_comb begin
    lim = (limit_r < LIMIT_MIN) ? LIMIT_MIN : limit_r;
    if (mark_r && lim < LIMIT_MIN_MARKED) begin
      lim = LIMIT_MIN_MARKED;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    chars_nxt     = chars_r;
    fill_nxt      = fill_r;
    cut_nxt       = cut_r;
    high_nxt      = high_r;
    stuck_nxt     = stuck_r;
    tail_we       = 1'b0;
    route         = 1'b0;
    index         = '0;
    cmd.kind      = CMD_NONE;
    cmd.data      = in_byte_r;
    cmd.fill      = '0;
    cmd.truncated = cut_r;
    cmd.non_ascii = high_r;
    cmd.count     = chars_r;
    cmd.saturated = stuck_r;

    if (in_end_r) begin
      cmd.kind  = CMD_FLUSH;
      cmd.fill  = cut_r ? '0 : fill_r;
      phase_nxt = PH_IDLE;
      chars_nxt = '0;
      fill_nxt  = '0;
      cut_nxt   = 1'b0;
      high_nxt  = 1'b0;
      stuck_nxt = 1'b0;
    end else begin
      phase_nxt = dec_phase;
      if (dec_cont) begin
        index = chars_ext;
        route = !cut_r;
      end else begin
        if (chars_r != '1) begin
          chars_nxt = chars_r + COUNT_WIDTH'(1);
        end else begin
          stuck_nxt = 1'b1;
        end
        if (!cut_r) begin
          if (chars_ext >= lim_ext) begin
            cut_nxt  = 1'b1;
            fill_nxt = '0;
            if (mark_r) begin
              cmd.kind = CMD_DOTS;
            end
          end else begin
            if (in_byte_r[DATA_WIDTH-1]) begin
              high_nxt = 1'b1;
            end
            index = chars_ext + EXT_W'(1);
            route = 1'b1;
          end
        end
      end
      if (route && index <= lim_ext) begin
        if (mark_r && (index + EXT_W'(2)) > lim_ext) begin
          if (fill_r < FILL_W'(TAIL_DEPTH)) begin
            tail_we  = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
          end
        end else begin
          cmd.kind = CMD_BYTE;
        end
      end
    end
  end

  // tail writes wait while the sequencer may still be reading the buffer
  assign take     = in_valid_r && (((cmd.kind == CMD_NONE) && !tail_we) || cmd_ready);
  assign in_ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      limit_r    <= LIMIT_RESET;
      mark_r     <= 1'b0;
      phase_r    <= PH_IDLE;
      chars_r    <= '0;
      fill_r     <= '0;
      cut_r      <= 1'b0;
      high_r     <= 1'b0;
      stuck_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHAR_LIMIT: limit_r <= cfg_data[LIMIT_WIDTH-1:0];
          REG_MARK:       mark_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (take) begin
        phase_r <= phase_nxt;
        chars_r <= chars_nxt;
        fill_r  <= fill_nxt;
        cut_r   <= cut_nxt;
        high_r  <= high_nxt;
        stuck_r <= stuck_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte_value;
      in_end_r  <= in_is_end;
    end
    if (take && tail_we) begin
      tail_mem[fill_r[TAIL_AW-1:0]] <= in_byte_r;
    end
  end

  ute_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cmd_valid           (in_valid_r),
    .cmd_ready           (cmd_ready),
    .rd_idx              (rd_idx),
    .rd_data             (tail_mem[rd_idx]),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_has_byte        (out_has_byte),
    .out_is_last         (out_is_last),
    .out_truncated       (out_truncated),
    .out_non_ascii       (out_non_ascii),
    .out_char_total      (out_char_total),
    .out_count_saturated (out_count_saturated)
  );

endmodule
`default_nettype wire

FILE: design/ute_decode.sv
`default_nettype none
module ute_decode (
  input  wire logic [ute_pkg::DATA_WIDTH-1:0] byte_value,
  input  wire ute_pkg::phase_t                phase,
  output ute_pkg::phase_t                     next_phase,
  output logic                                is_cont
);
  import ute_pkg::*;

  logic [DATA_WIDTH-1:0] lo;
  logic [DATA_WIDTH-1:0] hi;
  phase_t                cont_next;
  phase_t                lead;

  always_comb begin
    lo        = 8'h80;
    hi        = 8'hBF;
    cont_next = PH_IDLE;
    case (phase)
      PH_TAIL1: begin
        cont_next = PH_IDLE;
      end
      PH_TAIL2: begin
        cont_next = PH_TAIL1;
      end
      PH_TAIL3: begin
        cont_next = PH_TAIL2;
      end
      PH_E0: begin
        lo        = 8'hA0;
        cont_next = PH_TAIL1;
      end
      PH_ED: begin
        hi        = 8'h9F;
        cont_next = PH_TAIL1;
      end
      PH_F0: begin
        lo        = 8'h90;
        cont_next = PH_TAIL2;
      end
      PH_F4: begin
        hi        = 8'h8F;
        cont_next = PH_TAIL2;
      end
      default: begin
        cont_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    if (byte_value >= 8'hC2 && byte_value <= 8'hDF) begin
      lead = PH_TAIL1;
    end else if (byte_value == 8'hE0) begin
      lead = PH_E0;
    end else if (byte_value == 8'hED) begin
      lead = PH_ED;
    end else if (byte_value >= 8'hE1 && byte_value <= 8'hEF) begin
      lead = PH_TAIL2;
    end else if (byte_value == 8'hF0) begin
      lead = PH_F0;
    end else if (byte_value >= 8'hF1 && byte_value <= 8'hF3) begin
      lead = PH_TAIL3;
    end else if (byte_value == 8'hF4) begin
      lead = PH_F4;
    end else begin
      lead = PH_IDLE;
    end
  end

  assign is_cont    = (phase != PH_IDLE) && (byte_value >= lo) && (byte_value <= hi);
  assign next_phase = is_cont ? cont_next : lead;

endmodule
`default_nettype wire

FILE: design/ute_emit.sv
`default_nettype none
module ute_emit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ute_pkg::emit_cmd_t               cmd,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  output logic [ute_pkg::TAIL_AW-1:0]           rd_idx,
  input  wire logic [ute_pkg::DATA_WIDTH-1:0]   rd_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ute_pkg::DATA_WIDTH-1:0]        out_byte,
  output logic                                  out_has_byte,
  output logic                                  out_is_last,
  output logic                                  out_truncated,
  output logic                                  out_non_ascii,
  output logic [ute_pkg::COUNT_WIDTH-1:0]       out_char_total,
  output logic                                  out_count_saturated
);
  import ute_pkg::*;

  logic                   out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0]  byte_r, byte_nxt;
  logic                   has_r, has_nxt;
  logic                   last_r, last_nxt;
  logic                   trunc_r, trunc_nxt;
  logic                   nasc_r, nasc_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   sat_r, sat_nxt;

  logic                   busy_r, busy_nxt;
  cmd_kind_t              kind_r, kind_nxt;
  logic [TAIL_AW-1:0]     idx_r, idx_nxt;
  logic [FILL_W-1:0]      n_r, n_nxt;
  logic                   s_trunc_r, s_trunc_nxt;
  logic                   s_nasc_r, s_nasc_nxt;
  logic [COUNT_WIDTH-1:0] s_count_r, s_count_nxt;
  logic                   s_sat_r, s_sat_nxt;

  logic                   slot_free;
  logic                   flush_last;

  assign slot_free  = !out_valid_r || out_ready;
  assign cmd_ready  = !busy_r && slot_free;
  assign rd_idx     = busy_r ? idx_r : '0;
  assign flush_last = (FILL_W'(idx_r) + FILL_W'(1)) == n_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    byte_nxt      = byte_r;
    has_nxt       = has_r;
    last_nxt      = last_r;
    trunc_nxt     = trunc_r;
    nasc_nxt      = nasc_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    s_trunc_nxt   = s_trunc_r;
    s_nasc_nxt    = s_nasc_r;
    s_count_nxt   = s_count_r;
    s_sat_nxt     = s_sat_r;

    if (busy_r && slot_free) begin
      out_valid_nxt = 1'b1;
      has_nxt       = 1'b1;
      last_nxt      = 1'b0;
      trunc_nxt     = 1'b0;
      nasc_nxt      = 1'b0;
      count_nxt     = '0;
      sat_nxt       = 1'b0;
      case (kind_r)
        CMD_DOTS: begin
          byte_nxt = DOT_CHAR;
          busy_nxt = 1'b0;
        end
        CMD_FLUSH: begin
          byte_nxt = rd_data;
          idx_nxt  = idx_r + TAIL_AW'(1);
          if (flush_last) begin
            busy_nxt  = 1'b0;
            last_nxt  = 1'b1;
            trunc_nxt = s_trunc_r;
            nasc_nxt  = s_nasc_r;
            count_nxt = s_count_r;
            sat_nxt   = s_sat_r;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (cmd_valid && cmd_ready && cmd.kind != CMD_NONE) begin
      out_valid_nxt = 1'b1;
      has_nxt       = 1'b1;
      last_nxt      = 1'b0;
      trunc_nxt     = 1'b0;
      nasc_nxt      = 1'b0;
      count_nxt     = '0;
      sat_nxt       = 1'b0;
      kind_nxt      = cmd.kind;
      idx_nxt       = TAIL_AW'(1);
      n_nxt         = cmd.fill;
      s_trunc_nxt   = cmd.truncated;
      s_nasc_nxt    = cmd.non_ascii;
      s_count_nxt   = cmd.count;
      s_sat_nxt     = cmd.saturated;
      case (cmd.kind)
        CMD_BYTE: begin
          byte_nxt = cmd.data;
        end
        CMD_DOTS: begin
          byte_nxt = DOT_CHAR;
          busy_nxt = 1'b1;
        end
        CMD_FLUSH: begin
          if (cmd.fill == '0) begin
            byte_nxt = '0;
            has_nxt  = 1'b0;
          end else begin
            byte_nxt = rd_data;
          end
          if (cmd.fill <= FILL_W'(1)) begin
            last_nxt  = 1'b1;
            trunc_nxt = cmd.truncated;
            nasc_nxt  = cmd.non_ascii;
            count_nxt = cmd.count;
            sat_nxt   = cmd.saturated;
          end else begin
            busy_nxt = 1'b1;
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    has_r     <= has_nxt;
    last_r    <= last_nxt;
    trunc_r   <= trunc_nxt;
    nasc_r    <= nasc_nxt;
    count_r   <= count_nxt;
    sat_r     <= sat_nxt;
    kind_r    <= kind_nxt;
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    s_trunc_r <= s_trunc_nxt;
    s_nasc_r  <= s_nasc_nxt;
    s_count_r <= s_count_nxt;
    s_sat_r   <= s_sat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = byte_r;
  assign out_has_byte        = has_r;
  assign out_is_last         = last_r;
  assign out_truncated       = trunc_r;
  assign out_non_ascii       = nasc_r;
  assign out_char_total      = count_r;
  assign out_count_saturated = sat_r;

endmodule
`default_nettype wire

FILE: design/ute_checker.sv
`default_nettype none
module ute_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [ute_pkg::DATA_WIDTH-1:0] out_byte,
  input  wire logic                           out_has_byte,
  input  wire logic                           out_is_last,
  input  wire logic                           out_truncated,
  input  wire logic                           out_non_ascii,
  input  wire logic [ute_pkg::COUNT_WIDTH-1:0] out_char_total,
  input  wire logic                           out_count_saturated
);

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_is_last))
    else $error("result changed while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_is_last && (out_byte == '0))
    else $error("byteless result not final");

  a_summary_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_has_byte && !out_truncated && !out_non_ascii
      && (out_char_total == '0) && !out_count_saturated)
    else $error("summary fields set on a non-final result");

  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_saturated |-> (out_char_total == '1))
    else $error("saturated count not at maximum");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_truncate_with_ellipsis ute_checker u_ute_checker (.*);
`default_nettype wire

FILE: tb/utf8_trunc_check.sv
`timescale 1ns / 100ps
module utf8_trunc_check
  import ute_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [DATA_WIDTH-1:0]  in_byte_value,
  input  wire logic                   in_is_end,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [DATA_WIDTH-1:0]  out_byte,
  input  wire logic                   out_has_byte,
  input  wire logic                   out_is_last,
  input  wire logic                   out_truncated,
  input  wire logic                   out_non_ascii,
  input  wire logic [COUNT_WIDTH-1:0] out_char_total,
  input  wire logic                   out_count_saturated,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  output int                          fail_count,
  output int                          results_due
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  data;
    logic                   has_byte;
    logic                   is_last;
    logic                   truncated;
    logic                   non_ascii;
    logic [COUNT_WIDTH-1:0] count;
    logic                   saturated;
  } str_out_t;

  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] E0_CONT_MIN = 8'hA0;
  localparam logic [7:0] ED_CONT_MAX = 8'h9F;
  localparam logic [7:0] F0_CONT_MIN = 8'h90;
  localparam logic [7:0] F4_CONT_MAX = 8'h8F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF3;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam int unsigned COUNT_MAX  = (32'd1 << COUNT_WIDTH) - 1;

  logic [LIMIT_WIDTH-1:0] limit_reg;
  logic                   mark_reg;
  phase_t                 phase;
  int unsigned            chars_seen;
  logic [7:0]             tail_buf [TAIL_DEPTH];
  int unsigned            tail_len;
  bit                     cut;
  bit                     high_seen;
  bit                     stuck;
  str_out_t               awaited [$];

  function automatic phase_t lead_of(logic [7:0] b);
    if (b >= LEAD2_MIN && b <= LEAD2_MAX) return PH_TAIL1;
    if (b == LEAD_E0) return PH_E0;
    if (b == LEAD_ED) return PH_ED;
    if (b > LEAD_E0 && b <= LEAD3_MAX) return PH_TAIL2;
    if (b == LEAD_F0) return PH_F0;
    if (b > LEAD_F0 && b <= LEAD4_MAX) return PH_TAIL3;
    if (b == LEAD_F4) return PH_F4;
    return PH_IDLE;
  endfunction

  task automatic restart_string();
    phase = PH_IDLE;
    chars_seen = 0;
    tail_len = 0;
    cut = 0;
    high_seen = 0;
    stuck = 0;
  endtask

  task automatic queue_byte(logic [7:0] b);
    str_out_t r;
    r = '0;
    r.data = b;
    r.has_byte = 1'b1;
    awaited.push_back(r);
  endtask

  task automatic take_byte(logic [7:0] b);
    int unsigned lim;
    int unsigned idx;
    int unsigned prior;
    logic [7:0]  lo;
    logic [7:0]  hi;
    phase_t      nxt;
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (mark_reg && lim < 3) lim = 3;
    lo = CONT_MIN;
    hi = CONT_MAX;
    nxt = PH_IDLE;
    case (phase)
      PH_TAIL2: nxt = PH_TAIL1;
      PH_TAIL3: nxt = PH_TAIL2;
      PH_E0: begin
        lo = E0_CONT_MIN;
        nxt = PH_TAIL1;
      end
      PH_ED: begin
        hi = ED_CONT_MAX;
        nxt = PH_TAIL1;
      end
      PH_F0: begin
        lo = F0_CONT_MIN;
        nxt = PH_TAIL2;
      end
      PH_F4: begin
        hi = F4_CONT_MAX;
        nxt = PH_TAIL2;
      end
      default: ;
    endcase
    if (phase != PH_IDLE && b >= lo && b <= hi) begin
      phase = nxt;
      if (cut) return;
      idx = chars_seen;
    end else begin
      prior = chars_seen;
      phase = lead_of(b);
      if (chars_seen < COUNT_MAX) chars_seen++;
      else stuck = 1;
      if (cut) return;
      if (prior >= lim) begin
        cut = 1;
        tail_len = 0;
        if (mark_reg) begin
          queue_byte(DOT_CHAR);
          queue_byte(DOT_CHAR);
        end
        return;
      end
      if (b[7]) high_seen = 1;
      idx = prior + 1;
    end
    if (idx > lim) return;
    // last two kept characters held back until the string ends untruncated
    if (mark_reg && idx + 2 > lim) begin
      if (tail_len < TAIL_DEPTH) begin
        tail_buf[tail_len] = b;
        tail_len++;
      end
      return;
    end
    queue_byte(b);
  endtask

  task automatic close_string();
    str_out_t r;
    int       n;
    n = 0;
    if (!cut) begin
      for (int i = 0; i < tail_len; i++) begin
        queue_byte(tail_buf[i]);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      awaited.push_back(r);
    end
    r = awaited[$];
    awaited.pop_back();
    r.is_last = 1'b1;
    r.truncated = cut;
    r.non_ascii = high_seen;
    r.count = chars_seen[COUNT_WIDTH-1:0];
    r.saturated = stuck;
    awaited.push_back(r);
    restart_string();
  endtask

  always @(posedge clk) begin : track
    str_out_t want;
    bit       bad;
    if (!rst_n) begin
      limit_reg = LIMIT_RESET;
      mark_reg = 1'b0;
      restart_string();
      awaited.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result transfer: out_byte %0h", out_byte);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          bad = 0;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            bad = 1;
          end
          if (out_has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_has_byte);
            bad = 1;
          end
          if (out_is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, out_is_last);
            bad = 1;
          end
          if (out_truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, out_truncated);
            bad = 1;
          end
          if (out_non_ascii !== want.non_ascii) begin
            $error("non_ascii: expected %0b, got %0b", want.non_ascii, out_non_ascii);
            bad = 1;
          end
          if (out_char_total !== want.count) begin
            $error("char_total: expected %0d, got %0d", want.count, out_char_total);
            bad = 1;
          end
          if (out_count_saturated !== want.saturated) begin
            $error("count_saturated: expected %0b, got %0b", want.saturated,
                   out_count_saturated);
            bad = 1;
          end
          if (bad) fail_count++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_reg_t'(cfg_index) == REG_CHAR_LIMIT) limit_reg = cfg_data[LIMIT_WIDTH-1:0];
        else if (cfg_reg_t'(cfg_index) == REG_MARK) mark_reg = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        if (in_is_end) close_string();
        else take_byte(in_byte_value);
      end
    end
    results_due = awaited.size();
  end

endmodule

FILE: tb/tb_utf8_truncate_with_ellipsis.sv
`timescale 1ns / 100ps
module tb_utf8_truncate_with_ellipsis;
  import ute_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [DATA_WIDTH-1:0]  in_byte_value;
  logic                   in_is_end;
  logic                   out_valid;
  logic                   out_ready;
  logic [DATA_WIDTH-1:0]  out_byte;
  logic                   out_has_byte;
  logic                   out_is_last;
  logic                   out_truncated;
  logic                   out_non_ascii;
  logic [COUNT_WIDTH-1:0] out_char_total;
  logic                   out_count_saturated;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  int                     fail_count;
  int                     results_due;

  bit                     src_idle = 1;
  bit                     sink_idle = 1;
  int                     sink_hold = 0;
  int                     items_sent = 0;
  logic [7:0]             str_bytes [$];

  utf8_truncate_with_ellipsis uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte_value       (in_byte_value),
    .in_is_end           (in_is_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_has_byte        (out_has_byte),
    .out_is_last         (out_is_last),
    .out_truncated       (out_truncated),
    .out_non_ascii       (out_non_ascii),
    .out_char_total      (out_char_total),
    .out_count_saturated (out_count_saturated),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  utf8_trunc_check u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte_value       (in_byte_value),
    .in_is_end           (in_is_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_has_byte        (out_has_byte),
    .out_is_last         (out_is_last),
    .out_truncated       (out_truncated),
    .out_non_ascii       (out_non_ascii),
    .out_char_total      (out_char_total),
    .out_count_saturated (out_count_saturated),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .results_due         (results_due)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready <= 0;
        sink_hold--;
      end else if (sink_idle && $urandom_range(0, 99) < 15) begin
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic e);
    @(negedge clk);
    if (src_idle) begin
      while ($urandom_range(0, 99) < 15) begin
        in_valid <= 0;
        @(negedge clk);
      end
    end
    in_valid <= 1;
    in_byte_value <= b;
    in_is_end <= e;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_item(str_bytes[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    str_bytes.delete();
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic configure(logic [15:0] limit, logic mark);
    settle();
    write_reg(REG_CHAR_LIMIT, limit);
    write_reg(REG_MARK, CFG_W'(mark));
  endtask

  // mostly well-formed characters, some cut-short sequences and raw bytes
  task automatic push_char();
    int         pick;
    int         len;
    int         keep;
    logic [7:0] seq [4];
    pick = int'($urandom_range(0, 99));
    if (pick >= 92) begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    len = pick < 45 ? 1 : pick < 60 ? 2 : pick < 72 ? 3 : pick < 82 ? 4 :
          int'($urandom_range(2, 4));
    for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'h80, 8'hBF));
    case (len)
      1: seq[0] = 8'($urandom_range(0, 127));
      2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
      3: begin
        seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
        if (seq[0] == 8'hE0) seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
        else if (seq[0] == 8'hED) seq[1] = 8'($urandom_range(8'h80, 8'h9F));
      end
      default: begin
        seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
        if (seq[0] == 8'hF0) seq[1] = 8'($urandom_range(8'h90, 8'hBF));
        else if (seq[0] == 8'hF4) seq[1] = 8'($urandom_range(8'h80, 8'h8F));
      end
    endcase
    keep = (pick >= 82) ? int'($urandom_range(1, len - 1)) : len;
    for (int i = 0; i < keep; i++) str_bytes.push_back(seq[i]);
  endtask

  task automatic random_strings(int n_items, int max_chars);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      repeat ($urandom_range(0, max_chars)) push_char();
      send_string();
    end
  endtask

  initial begin : stimulus
    int half;
    int drain;
    rst_n = 0;
    in_valid = 0;
    in_byte_value = '0;
    in_is_end = 0;
    cfg_wr_en = 0;
    cfg_index = REG_CHAR_LIMIT;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1;

    // boundary continuations of the C2, E0, ED, F0 and F4 leads, ill-formed leads, NUL, empty string
    str_bytes = '{8'h00, 8'h7F, 8'hFF, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F,
                  8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0,
                  8'h80, 8'hC0};
    send_string();
    send_string();
    configure(16'd3, 1'b1);
    str_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h5A};
    send_string();

    configure(16'd1, 1'b0);
    random_strings(20, 6);
    configure(16'd0, 1'b1);
    random_strings(20, 8);
    configure(16'd2, 1'b1);
    random_strings(20, 8);
    configure(16'd4, 1'b1);
    random_strings(20, 10);

    // register change part-way through a string
    repeat (10) push_char();
    half = str_bytes.size() / 2;
    for (int i = 0; i < half; i++) send_item(str_bytes[i], 1'b0);
    settle();
    write_reg(REG_MARK, CFG_W'(0));
    for (int i = half; i < str_bytes.size(); i++) send_item(str_bytes[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    str_bytes.delete();

    configure(16'hFFFF, 1'b1);
    random_strings(30, 12);

    // no idling, with the result side stalled long enough to back up the input
    configure(16'hFFFF, 1'b0);
    src_idle = 0;
    sink_idle = 0;
    sink_hold = 80;
    random_strings(40, 16);
    src_idle = 1;
    sink_idle = 1;

    configure(16'd5, 1'b1);
    random_strings(25, 10);
    configure(16'd3, 1'b1);
    random_strings(25, 10);

    @(negedge clk);
    in_valid <= 0;
    drain = 0;
    while (results_due != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ute_pkg.sv
design/ute_decode.sv
design/ute_emit.sv
design/utf8_truncate_with_ellipsis.sv
design/ute_checker.sv
tb/utf8_trunc_check.sv
tb/tb_utf8_truncate_with_ellipsis.sv
